>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when building for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk edge, ignored while rst_n is low.
`define SLCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define SLCP_ASSERT_IMPLY(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
`else
`define SLCP_ASSERT(lbl, prop, msg)
`define SLCP_ASSERT_IMPLY(lbl, cond, cons, msg)
`endif

`endif

>>> rtl/slcp_pkg.sv
package slcp_pkg;

    // Widths of the request and result fields
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IDENT_W   = 12;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned DCNT_W    = 5;

    localparam int unsigned MAX_DATA_BYTES = 8;
    localparam int unsigned IDENT_DIGITS   = 3;

    // Characters of the serial protocol
    localparam logic [BYTE_W-1:0] CHR_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CHR_CR = 8'h0D;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_IDENT = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_TERM  = 3'd4
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BADHEX  = 2'd1,
        ST_TOOLONG = 2'd2,
        ST_NOTERM  = 2'd3
    } status_t;

    // Held byte from the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rx_hold_t;

    // One result from the decoder towards the output register
    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic [IDENT_W-1:0]   ident;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Decode one ASCII hex digit, either case
    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.val = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.val = 4'(c - 8'h57);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

>>> rtl/slcp_ifs.sv
interface slcp_rx_if;
    import slcp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcp_frame_if;
    import slcp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [IDENT_W-1:0]   ident;
    logic [LEN_W-1:0]     length;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output status, output ident, output length,
                    output payload, input ready);
    modport sink (input valid, input status, input ident, input length,
                  input payload, output ready);
endinterface

>>> rtl/slcp_in_stage.sv
module slcp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    slcp_rx_if.sink            rx,
    input  logic               slot_free,
    output slcp_pkg::rx_hold_t held,
    output logic               advance
);
    import slcp_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    // Step the decoder when a byte is held and the result slot can take it
    assign advance  = valid_reg && slot_free;
    assign rx.ready = !valid_reg || advance;

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

    // Capture the next request, drop the held one once decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            data_reg <= rx.rx_byte;
        end
    end

endmodule

>>> rtl/slcp_decoder.sv
`include "assert_macros.svh"

module slcp_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  slcp_pkg::rx_hold_t  held,
    output slcp_pkg::result_t   res
);
    import slcp_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [IDENT_W-1:0]   ident_reg, ident_next;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;

    hex_t              hx;
    logic [DCNT_W-1:0] dcnt_inc;
    logic [5:0]        shift;
    logic              len_too_big;

    assign hx          = hex_decode(held.data);
    assign dcnt_inc    = dcnt_reg + DCNT_W'(1);
    // High nibble of each byte comes first
    assign shift       = {dcnt_reg[3:1], ~dcnt_reg[0], 2'b00};
    assign len_too_big = {1'b0, hx.val} > (LEN_W+1)'(MAX_DATA_BYTES);

    // Next state and accumulators
    always_comb
    begin
        phase_next   = phase_reg;
        ident_next   = ident_reg;
        length_next  = length_reg;
        payload_next = payload_reg;
        dcnt_next    = dcnt_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (held.data == CHR_T)
                    begin
                        ident_next   = '0;
                        length_next  = '0;
                        payload_next = '0;
                        dcnt_next    = '0;
                        phase_next   = PH_IDENT;
                    end
                end
                PH_IDENT:
                begin
                    if (!hx.ok)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        ident_next = {ident_reg[IDENT_W-5:0], hx.val};
                        dcnt_next  = dcnt_inc;
                        if (dcnt_inc >= DCNT_W'(IDENT_DIGITS))
                        begin
                            dcnt_next  = '0;
                            phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (!hx.ok || len_too_big)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        length_next = hx.val;
                        dcnt_next   = '0;
                        phase_next  = (hx.val == '0) ? PH_HUNT : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (!hx.ok)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        payload_next = payload_reg | (PAYLOAD_W'(hx.val) << shift);
                        dcnt_next    = dcnt_inc;
                        if (dcnt_inc >= {length_reg, 1'b0})
                        begin
                            dcnt_next  = '0;
                            phase_next = PH_TERM;
                        end
                    end
                end
                PH_TERM:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Result for the byte being decoded
    always_comb
    begin
        res = '0;
        if (step)
        begin
            unique case (phase_reg)
                PH_IDENT:
                begin
                    if (!hx.ok)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_BADHEX;
                    end
                end
                PH_LEN:
                begin
                    if (!hx.ok)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_BADHEX;
                    end
                    else if (len_too_big)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_TOOLONG;
                    end
                    else if (hx.val == '0)
                    begin
                        res.valid   = 1'b1;
                        res.status  = ST_OK;
                        res.ident   = ident_reg;
                        res.length  = hx.val;
                        res.payload = payload_reg;
                    end
                end
                PH_DATA:
                begin
                    if (!hx.ok)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_BADHEX;
                    end
                end
                PH_TERM:
                begin
                    res.valid = 1'b1;
                    if (held.data == CHR_CR)
                    begin
                        res.status  = ST_OK;
                        res.ident   = ident_reg;
                        res.length  = length_reg;
                        res.payload = payload_reg;
                    end
                    else
                    begin
                        res.status = ST_NOTERM;
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            dcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_reg   <= ident_next;
        length_reg  <= length_next;
        payload_reg <= payload_next;
    end

    `SLCP_ASSERT_IMPLY(a_err_fields_zero, res.valid && res.status != ST_OK,
        res.ident == '0 && res.length == '0 && res.payload == '0,
        "error result carries data")
    `SLCP_ASSERT(a_result_rehunts, res.valid |=> phase_reg == PH_HUNT,
        "decoder not hunting after a result")
    `SLCP_ASSERT_IMPLY(a_ident_count, phase_reg == PH_IDENT,
        dcnt_reg < DCNT_W'(IDENT_DIGITS), "identifier digit count overrun")
    `SLCP_ASSERT_IMPLY(a_data_count, phase_reg == PH_DATA,
        length_reg != '0 && dcnt_reg < {length_reg, 1'b0}, "data digit count overrun")

endmodule

>>> rtl/slcp_out_stage.sv
module slcp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  slcp_pkg::result_t res,
    output logic              slot_free,
    slcp_frame_if.source      frame
);
    import slcp_pkg::*;

    logic                 valid_reg;
    status_t              status_reg;
    logic [IDENT_W-1:0]   ident_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic                 load;

    assign slot_free = !valid_reg || frame.ready;
    assign load      = advance && res.valid;

    assign frame.valid   = valid_reg;
    assign frame.status  = status_reg;
    assign frame.ident   = ident_reg;
    assign frame.length  = length_reg;
    assign frame.payload = payload_reg;

    // Hold the result until taken, refill when a new one arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= res.status;
            ident_reg   <= res.ident;
            length_reg  <= res.length;
            payload_reg <= res.payload;
        end
    end

endmodule

>>> rtl/slcan_ascii_frame_parser.sv
// Channel  Dir  Handshake      Payload
// rx       in   valid/ready    rx_byte[7:0]
// frame    out  valid/ready    status[1:0] ident[11:0] length[3:0] payload[63:0]
//
// One byte is taken per cycle unless an untaken result holds the decoder; a byte is
// decoded from the input register and its result, if any, is registered onto frame.
// The decode step is a single pass from the input register to the output register.
// Reset clears the valid flags and returns the decoder to hunting for 't'.
// A result not yet taken holds the decoder; rx stays ready while the input
// register is empty.
module slcan_ascii_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    slcp_rx_if.sink      rx,
    slcp_frame_if.source frame
);
    import slcp_pkg::*;

    rx_hold_t held;
    result_t  res;
    logic     advance;
    logic     slot_free;

    slcp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .slot_free (slot_free),
        .held      (held),
        .advance   (advance)
    );

    slcp_decoder u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .held  (held),
        .res   (res)
    );

    slcp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res       (res),
        .slot_free (slot_free),
        .frame     (frame)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import slcp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // One decoded frame, or an error, as the block should report it
    typedef struct {
        status_t              status;
        logic [IDENT_W-1:0]   ident;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
    } frame_rec_t;

    logic clk;
    logic rst_n;

    slcp_rx_if    rx_ch ();
    slcp_frame_if frame_ch ();

    slcan_ascii_frame_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch)
    );

    // Decoder state as tracked by the testbench
    phase_t               dec_phase;
    logic [IDENT_W-1:0]   dec_ident;
    logic [LEN_W-1:0]     dec_len;
    logic [PAYLOAD_W-1:0] dec_payload;
    logic [DCNT_W-1:0]    dec_count;

    frame_rec_t pending_frames[$];
    int         busy_items;
    int         errors;
    bit         src_idle_on;
    bit         sink_idle_on;
    int         stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Decode one ASCII hex digit: {valid, value}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            return {1'b1, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            return {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return 5'd0;
    endfunction

    // Hex character for a nibble, random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Any byte that is not a hex digit, with 't' and CR favoured
    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [4:0] n;
        int         pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return CHR_T;
        end
        if (pick == 1)
        begin
            return CHR_CR;
        end
        do
        begin
            c = 8'($urandom_range(0, 255));
            n = nibble_of(c);
        end
        while (n[4]);
        return c;
    endfunction

    // Close the current frame with a result and go back to hunting
    task automatic post_frame(input status_t st);
        frame_rec_t r;
        r.status  = st;
        r.ident   = (st == ST_OK) ? dec_ident : '0;
        r.length  = (st == ST_OK) ? dec_len : '0;
        r.payload = (st == ST_OK) ? dec_payload : '0;
        pending_frames.push_back(r);
        dec_phase = PH_HUNT;
    endtask

    // Advance the tracked decoder by one accepted byte
    task automatic predict_frame_byte(input logic [7:0] c);
        logic [4:0] n;
        int         shift;
        n = nibble_of(c);
        if (dec_phase != PH_HUNT || c == CHR_T)
        begin
            busy_items++;
        end
        case (dec_phase)
            PH_IDENT:
            begin
                if (!n[4])
                begin
                    post_frame(ST_BADHEX);
                end
                else
                begin
                    dec_ident = {dec_ident[IDENT_W-5:0], n[3:0]};
                    dec_count++;
                    if (dec_count >= IDENT_DIGITS)
                    begin
                        dec_count = '0;
                        dec_phase = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                if (!n[4])
                begin
                    post_frame(ST_BADHEX);
                end
                else if (n[3:0] > MAX_DATA_BYTES)
                begin
                    post_frame(ST_TOOLONG);
                end
                else
                begin
                    dec_len   = n[3:0];
                    dec_count = '0;
                    if (n[3:0] == 4'd0)
                    begin
                        post_frame(ST_OK);
                    end
                    else
                    begin
                        dec_phase = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (!n[4])
                begin
                    post_frame(ST_BADHEX);
                end
                else
                begin
                    // high nibble first within each byte
                    shift = 8 * ((dec_count >> 1) & 7) + (dec_count[0] ? 0 : 4);
                    dec_payload = dec_payload | (64'(n[3:0]) << shift);
                    dec_count++;
                    if (int'(dec_count) >= 2 * int'(dec_len))
                    begin
                        dec_count = '0;
                        dec_phase = PH_TERM;
                    end
                end
            end
            PH_TERM:
            begin
                post_frame((c == CHR_CR) ? ST_OK : ST_NOTERM);
            end
            default:
            begin
                if (c == CHR_T)
                begin
                    dec_ident   = '0;
                    dec_len     = '0;
                    dec_payload = '0;
                    dec_count   = '0;
                    dec_phase   = PH_IDENT;
                end
                else
                begin
                    dec_phase = PH_HUNT;
                end
            end
        endcase
    endtask

    // Offer one byte, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
        end
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!rx_ch.ready);
        predict_frame_byte(b);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(8'(s[i]));
        end
    endtask

    // Drop valid and hold until every pending frame has arrived
    task automatic drain_frames();
        rx_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Build one frame, well formed or with a single fault, or a burst of noise
    task automatic send_random_frame();
        logic [7:0]         q[$];
        logic [IDENT_W-1:0] id;
        logic [7:0]         d;
        int                 kind;
        int                 len;
        int                 pos;
        kind = $urandom_range(0, 99);
        if (kind >= 88)
        begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        len = $urandom_range(0, MAX_DATA_BYTES);
        if (kind >= 81 && len == 0)
        begin
            len = $urandom_range(1, MAX_DATA_BYTES);
        end
        id = IDENT_W'($urandom);
        q.push_back(CHR_T);
        for (int k = IDENT_DIGITS - 1; k >= 0; k--)
        begin
            q.push_back(hex_char(id[4*k +: 4]));
        end
        q.push_back(hex_char(4'(len)));
        for (int k = 0; k < len; k++)
        begin
            d = 8'($urandom);
            q.push_back(hex_char(d[7:4]));
            q.push_back(hex_char(d[3:0]));
        end
        if (len > 0 || $urandom_range(0, 3) == 0)
        begin
            q.push_back(CHR_CR);
        end
        if (kind >= 70 && kind < 76)
        begin
            // corrupt one digit of identifier, length or data
            pos = $urandom_range(1, 4 + 2 * len);
            q[pos] = rand_non_hex();
        end
        else if (kind >= 76 && kind < 81)
        begin
            q[4] = hex_char(4'($urandom_range(MAX_DATA_BYTES + 1, 15)));
            while (q.size() > 5)
            begin
                void'(q.pop_back());
            end
        end
        else if (kind >= 81)
        begin
            do
            begin
                d = 8'($urandom_range(0, 255));
            end
            while (d == CHR_CR);
            q[q.size() - 1] = d;
        end
        foreach (q[i])
        begin
            send_byte(q[i]);
        end
    endtask

    task automatic test_hunting();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHR_CR);
        send_text("Tx");
    endtask

    task automatic test_zero_length();
        // CR after a zero-length frame is skipped while hunting
        send_text("t0000\r");
    endtask

    task automatic test_full_frame();
        send_text("t987");
        send_text("8ABCDEFabcdef0123\r");
        send_text("tFFF1ff\r");
    endtask

    task automatic test_bad_hex();
        send_text("tg");
        send_text("t12\r");
        send_text("t12t");
        send_text("t1232G");
    endtask

    task automatic test_too_long();
        send_text("t1239");
        send_text("t123f");
    endtask

    task automatic test_no_terminator();
        send_text("t1231Ex");
    endtask

    // Random frames; reshuffle the idling pattern now and then when asked
    task automatic test_random_traffic(input int target, input bit vary_idle);
        int goal;
        goal = busy_items + target;
        while (busy_items < goal)
        begin
            if (vary_idle && $urandom_range(0, 29) == 0)
            begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_frame();
        end
    endtask

    task automatic test_drain_pause();
        drain_frames();
        test_random_traffic(40, 1'b1);
    endtask

    task automatic test_no_idle();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        stall_left   = 0;
        test_random_traffic(150, 1'b0);
    endtask

    // Sink side: stall in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            frame_ch.ready <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            frame_ch.ready <= 1'b0;
        end
        else
        begin
            frame_ch.ready <= 1'b1;
        end
    end

    // Compare each taken result with the oldest pending frame
    always @(posedge clk)
    begin : frame_check
        frame_rec_t want;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("unexpected frame: status %0d ident %h length %0d payload %h",
                       frame_ch.status, frame_ch.ident, frame_ch.length, frame_ch.payload);
                errors++;
            end
            else
            begin
                want = pending_frames.pop_front();
                if (frame_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, frame_ch.status);
                    errors++;
                end
                if (frame_ch.ident !== want.ident)
                begin
                    $error("ident: expected %h, actual %h", want.ident, frame_ch.ident);
                    errors++;
                end
                if (frame_ch.length !== want.length)
                begin
                    $error("length: expected %0d, actual %0d", want.length, frame_ch.length);
                    errors++;
                end
                if (frame_ch.payload !== want.payload)
                begin
                    $error("payload: expected %h, actual %h", want.payload, frame_ch.payload);
                    errors++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        frame_ch.ready = 1'b0;
        dec_phase      = PH_HUNT;
        dec_ident      = '0;
        dec_len        = '0;
        dec_payload    = '0;
        dec_count      = '0;
        busy_items     = 0;
        errors         = 0;
        stall_left     = 0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_hunting();
        test_zero_length();
        test_full_frame();
        test_bad_hex();
        test_too_long();
        test_no_terminator();
        test_random_traffic(450, 1'b1);
        test_drain_pause();
        test_random_traffic(400, 1'b1);
        test_no_idle();

        // Drain, then allow the pipeline to settle
        drain_frames();
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
